### hw/rtl/tbh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the take-back-half speed controller.
// No dependencies; imported by tbh_step and take_back_half_speed_controller_core.
package tbh_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] REG_SETPOINT = 2'd0;
    localparam logic [1:0] REG_GAIN     = 2'd1;

    // reset values of the configuration registers
    localparam logic [13:0] TARGET_RESET = 14'd0;
    localparam logic [15:0] GAIN_RESET   = 16'd6554;

    // drive limit: 100 percent in Q7.8
    localparam logic [14:0] DRIVE_MAX = 15'd25600;

    // feed-forward line: ((target * FF_MUL) >> 12) - FF_OFFSET
    localparam logic [13:0]        FF_MUL    = 14'd11192;
    localparam logic signed [16:0] FF_OFFSET = 17'sd568;

    // millivolts per percent
    localparam logic [6:0] MV_PER_PERCENT = 7'd127;

    // error sign codes
    typedef enum logic [1:0] {
        SIGN_ZERO = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd3
    } sign_t;

    // loop state carried from one tick to the next
    typedef struct packed {
        logic [14:0] drive_acc;
        logic [14:0] take_back;
        sign_t       prev_sign;
        logic        first_cross;
        logic [13:0] prev_target;
    } tbh_state_t;

endpackage

### hw/rtl/tbh_step.sv
`timescale 1ns / 1ps
// One control tick of the take-back-half loop, purely combinational.
// Depends on tbh_pkg for the state struct, sign codes and constants.
module tbh_step
    import tbh_pkg::*;
(
    input  logic signed [14:0] speed_a,
    input  logic signed [14:0] speed_b,
    input  logic [13:0]        setpoint,
    input  logic [15:0]        gain,
    input  tbh_state_t         state_cur,
    output tbh_state_t         state_new,
    output logic [13:0]        drive_mv
);

    logic signed [15:0] speed_sum;
    logic signed [14:0] speed_avg;
    logic signed [16:0] error;
    logic signed [16:0] gain_s;
    logic signed [33:0] prod;
    logic signed [33:0] prod_adj;
    logic signed [21:0] inc;
    logic signed [22:0] acc_sum;
    logic [14:0]        drive_clamped;
    sign_t              err_sign;
    logic               first;
    logic [27:0]        ff_prod;
    logic [15:0]        ff_shift;
    logic signed [16:0] ff_diff;
    logic [14:0]        ff_drive;
    logic [15:0]        avg_sum;
    logic [14:0]        drive_final;
    logic [21:0]        mv_prod;

    // averaged speed, floor of the half sum
    assign speed_sum = {speed_a[14], speed_a} + {speed_b[14], speed_b};
    assign speed_avg = speed_sum[15:1];

    // error and its sign
    assign error = $signed({3'b000, setpoint})
                   - $signed({{2{speed_avg[14]}}, speed_avg});

    always_comb
    begin
        if (error == 17'sd0)
        begin
            err_sign = SIGN_ZERO;
        end
        else if (error[16])
        begin
            err_sign = SIGN_NEG;
        end
        else
        begin
            err_sign = SIGN_POS;
        end
    end

    // integral step, product divided by 4096 toward zero
    assign gain_s   = $signed({1'b0, gain});
    assign prod     = gain_s * error;
    assign prod_adj = prod + (prod[33] ? 34'sd4095 : 34'sd0);
    assign inc      = prod_adj[33:12];

    // accumulate and clamp to 0..100 percent
    assign acc_sum = $signed({8'd0, state_cur.drive_acc}) + $signed({inc[21], inc});

    always_comb
    begin
        if (acc_sum[22])
        begin
            drive_clamped = 15'd0;
        end
        else if (acc_sum > $signed({8'd0, DRIVE_MAX}))
        begin
            drive_clamped = DRIVE_MAX;
        end
        else
        begin
            drive_clamped = acc_sum[14:0];
        end
    end

    // feed-forward drive from the target, saturated
    assign ff_prod  = {14'd0, setpoint} * {14'd0, FF_MUL};
    assign ff_shift = ff_prod[27:12];
    assign ff_diff  = $signed({1'b0, ff_shift}) - FF_OFFSET;

    always_comb
    begin
        if (ff_diff[16])
        begin
            ff_drive = 15'd0;
        end
        else if (ff_diff > $signed({2'b00, DRIVE_MAX}))
        begin
            ff_drive = DRIVE_MAX;
        end
        else
        begin
            ff_drive = ff_diff[14:0];
        end
    end

    // take-back average
    assign avg_sum = {1'b0, drive_clamped} + {1'b0, state_cur.take_back};

    // a target change re-arms the feed-forward load
    assign first = state_cur.first_cross || (setpoint != state_cur.prev_target);

    // crossing handling and next state
    always_comb
    begin
        state_new             = state_cur;
        drive_final           = drive_clamped;
        state_new.first_cross = first;
        if (err_sign != state_cur.prev_sign)
        begin
            if (first)
            begin
                drive_final           = ff_drive;
                state_new.first_cross = 1'b0;
            end
            else
            begin
                drive_final = avg_sum[15:1];
            end
            state_new.take_back = drive_final;
        end
        state_new.drive_acc   = drive_final;
        state_new.prev_sign   = err_sign;
        state_new.prev_target = setpoint;
    end

    // millivolt output
    assign mv_prod  = {7'd0, drive_final} * {15'd0, MV_PER_PERCENT};
    assign drive_mv = mv_prod[21:8];

endmodule

### hw/rtl/take_back_half_speed_controller_core.sv
`timescale 1ns / 1ps
// Top level of the take-back-half flywheel speed controller.
// Depends on tbh_pkg and tbh_step.

// Takes one pair of motor speed samples per request and returns one drive command
// (percent in Q7.8 and millivolts) per request. A request is captured in an input
// register, the whole control tick is worked out combinationally by tbh_step, and the
// result lands in an output register; the loop state is updated in that same cycle,
// so a new request is accepted every clock unless a held result stalls the input, and
// each request passes the input register and then the output register, which holds
// its result while result_stall is high. Configuration registers: index 0 is the
// target speed, index 1 the gain; they are written through cfg_valid/cfg_ready, which
// is always ready, and should change only while no request is in flight.
module take_back_half_speed_controller_core
    import tbh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    // sample channel
    input  logic               sample_valid,
    output logic               sample_stall,
    input  logic signed [14:0] speed_a,
    input  logic signed [14:0] speed_b,
    // result channel
    output logic               result_valid,
    input  logic               result_stall,
    output logic [14:0]        drive_percent,
    output logic [13:0]        drive_mv
);

    logic [13:0]        target_reg;
    logic [15:0]        gain_reg;
    tbh_state_t         state_reg;
    tbh_state_t         state_next;
    logic               in_valid_reg;
    logic signed [14:0] in_speed_a_reg;
    logic signed [14:0] in_speed_b_reg;
    logic               out_valid_reg;
    logic [14:0]        out_percent_reg;
    logic [13:0]        out_mv_reg;
    logic [13:0]        mv_next;
    logic               advance;
    logic               in_load;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
            gain_reg   <= GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SETPOINT: target_reg <= cfg_data[13:0];
                REG_GAIN:     gain_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // handshake control
    assign advance      = in_valid_reg && (!out_valid_reg || !result_stall);
    assign sample_stall = in_valid_reg && !advance;
    assign in_load      = sample_valid && !sample_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!sample_stall)
        begin
            in_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_speed_a_reg <= speed_a;
            in_speed_b_reg <= speed_b;
        end
    end

    // control tick
    tbh_step u_step (
        .speed_a   (in_speed_a_reg),
        .speed_b   (in_speed_b_reg),
        .setpoint  (target_reg),
        .gain      (gain_reg),
        .state_cur (state_reg),
        .state_new (state_next),
        .drive_mv  (mv_next)
    );

    // loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.drive_acc   <= 15'd0;
            state_reg.take_back   <= 15'd0;
            state_reg.prev_sign   <= SIGN_ZERO;
            state_reg.first_cross <= 1'b1;
            state_reg.prev_target <= 14'd0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_percent_reg <= state_next.drive_acc;
            out_mv_reg      <= mv_next;
        end
    end

    assign result_valid  = out_valid_reg;
    assign drive_percent = out_percent_reg;
    assign drive_mv      = out_mv_reg;

    // checks
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_percent_reg <= DRIVE_MAX))
        else $error("drive beyond full scale");

    a_state_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg.drive_acc == out_percent_reg))
        else $error("loop state and shown drive disagree");

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("computed request lost");

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (in_valid_reg && out_valid_reg && result_stall))
        else $error("sample stalled without cause");

endmodule

### tb/sv/take_back_half_speed_controller_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for take_back_half_speed_controller_core: drives speed sample
// requests and register writes, predicts every drive command and checks it on arrival.
// Depends on tbh_pkg and the controller RTL.
module take_back_half_speed_controller_core_tb;
    import tbh_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 1900;
    localparam int HOLD_CYCLES  = 300;
    localparam int PRINT_CAP    = 200;

    typedef struct packed {
        logic signed [14:0] a;
        logic signed [14:0] b;
    } sample_pair_t;

    typedef struct packed {
        logic [14:0] pct;
        logic [13:0] mv;
    } drive_cmd_t;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index     = '0;
    logic [15:0]        cfg_data      = '0;
    logic               sample_valid  = 1'b0;
    logic               sample_stall;
    logic signed [14:0] speed_a       = '0;
    logic signed [14:0] speed_b       = '0;
    logic               result_valid;
    logic               result_stall  = 1'b0;
    logic [14:0]        drive_percent;
    logic [13:0]        drive_mv;

    // stimulus and scoreboard storage
    sample_pair_t pending_samples[$];
    drive_cmd_t   expected_drive_q[$];
    logic         sample_took     = 1'b0;
    int           items_taken     = 0;
    int           mismatch_count  = 0;
    int           quiet_cycles    = 0;

    // sender burst state
    int burst_left = 0;
    int gap_left   = 0;

    // receiver stall state
    int hold_left    = 0;
    int next_hold_at = 700;
    int stall_mode   = 0;
    int mode_left    = 0;

    // predictor copy of registers and loop state
    logic [13:0] set_target = TARGET_RESET;
    logic [15:0] set_gain   = GAIN_RESET;
    tbh_state_t  loop_st    = '{drive_acc: '0, take_back: '0, prev_sign: SIGN_ZERO,
                                first_cross: 1'b1, prev_target: '0};

    take_back_half_speed_controller_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .speed_a       (speed_a),
        .speed_b       (speed_b),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .drive_percent (drive_percent),
        .drive_mv      (drive_mv)
    );

    // clock
    always #5 clk = ~clk;

    function automatic int clamp_drive(input int v);
        if (v < 0)
            return 0;
        if (v > int'(DRIVE_MAX))
            return int'(DRIVE_MAX);
        return v;
    endfunction

    // one control tick: advances the loop state, returns the drive command
    function automatic drive_cmd_t predict_drive(input logic signed [14:0] sa,
                                                 input logic signed [14:0] sb);
        int         sum;
        int         spd;
        int         err;
        int         drv;
        int         ff;
        int         mv;
        longint     prod;
        longint     inc;
        sign_t      sg;
        drive_cmd_t res;
        sum  = int'(sa) + int'(sb);
        spd  = sum >>> 1;
        err  = int'(set_target) - spd;
        prod = longint'(set_gain) * longint'(err);
        inc  = prod / 4096;
        drv  = clamp_drive(int'(loop_st.drive_acc) + int'(inc));
        if (err > 0)
            sg = SIGN_POS;
        else if (err < 0)
            sg = SIGN_NEG;
        else
            sg = SIGN_ZERO;
        // a new setpoint rearms the feed-forward load
        if (set_target != loop_st.prev_target)
            loop_st.first_cross = 1'b1;
        // error crossed sign: reload the drive
        if (sg != loop_st.prev_sign)
        begin
            if (loop_st.first_cross)
            begin
                ff  = ((int'(set_target) * int'(FF_MUL)) >>> 12) - int'(FF_OFFSET);
                drv = clamp_drive(ff);
                loop_st.first_cross = 1'b0;
            end
            else
            begin
                drv = (drv + int'(loop_st.take_back)) >>> 1;
            end
            loop_st.take_back = drv[14:0];
        end
        loop_st.drive_acc   = drv[14:0];
        loop_st.prev_sign   = sg;
        loop_st.prev_target = set_target;
        mv      = (drv * int'(MV_PER_PERCENT)) >>> 8;
        res.pct = drv[14:0];
        res.mv  = mv[13:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t: mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // request driver: bursts of requests separated by random gaps
    always @(negedge clk)
    begin
        sample_pair_t nxt;
        if (rst_n && (!sample_valid || sample_took))
        begin
            if (gap_left != 0 || pending_samples.size() == 0)
            begin
                sample_valid <= 1'b0;
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                nxt = pending_samples.pop_front();
                sample_valid <= 1'b1;
                speed_a      <= nxt.a;
                speed_b      <= nxt.b;
                if (burst_left <= 1)
                begin
                    burst_left <= ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // result receiver: long hold-offs now and then, otherwise a changing stall pattern
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                result_stall <= 1'b1;
                hold_left    <= hold_left - 1;
            end
            else if (items_taken >= next_hold_at)
            begin
                result_stall <= 1'b1;
                hold_left    <= HOLD_CYCLES;
                next_hold_at <= next_hold_at + 900;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode <= $urandom_range(0, 3);
                    mode_left  <= $urandom_range(16, 200);
                end
                else
                begin
                    mode_left <= mode_left - 1;
                end
                case (stall_mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 3) == 0);
                    2:       result_stall <= ($urandom_range(0, 3) != 0);
                    default: result_stall <= !result_stall;
                endcase
            end
        end
    end

    // monitor: check results, track register writes, predict accepted requests
    always @(posedge clk)
    begin
        drive_cmd_t want;
        if (rst_n)
        begin
            sample_took <= sample_valid && !sample_stall;
            if (result_valid && !result_stall)
            begin
                if (expected_drive_q.size() == 0)
                begin
                    report_mismatch("unexpected result, drive_percent", drive_percent, -1);
                end
                else
                begin
                    want = expected_drive_q.pop_front();
                    if (drive_percent !== want.pct)
                        report_mismatch("drive_percent", drive_percent, want.pct);
                    if (drive_mv !== want.mv)
                        report_mismatch("drive_mv", drive_mv, want.mv);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SETPOINT: set_target = cfg_data[13:0];
                    REG_GAIN:     set_gain   = cfg_data;
                    default:      ;
                endcase
            end
            if (sample_valid && !sample_stall)
            begin
                expected_drive_q.push_back(predict_drive(speed_a, speed_b));
                items_taken++;
            end
        end
    end

    // watchdog: ends the run after too long with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL take_back_half_speed_controller_core");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_pair(input int a, input int b);
        sample_pair_t p;
        p.a = 15'(a);
        p.b = 15'(b);
        pending_samples.push_back(p);
    endtask

    // sender pause: wait until every request is taken and every result is back
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_samples.size() != 0 || sample_valid || expected_drive_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic signed [14:0] clip_speed(input int v);
        if (v > 16383)
            return 15'sd16383;
        if (v < -16384)
            return -15'sd16384;
        return 15'(v);
    endfunction

    // random speed pair, mostly hovering around the setpoint so the error keeps crossing
    function automatic sample_pair_t make_pair(input int tgt);
        sample_pair_t p;
        int           kind;
        int           spread;
        int           d;
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            p.a = 15'($urandom_range(0, 32767));
            p.b = 15'($urandom_range(0, 32767));
        end
        else if (kind < 30)
        begin
            // opposite offsets that average back to the setpoint
            d   = int'($urandom_range(0, 2000)) - 1000;
            p.a = clip_speed(tgt + d);
            p.b = clip_speed(tgt - d);
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:       spread = 4;
                1:       spread = 60;
                default: spread = 1500;
            endcase
            p.a = clip_speed(tgt + int'($urandom_range(0, 2 * spread)) - spread);
            p.b = clip_speed(tgt + int'($urandom_range(0, 2 * spread)) - spread);
        end
        return p;
    endfunction

    // reset, directed requests, then random phases with fresh settings
    initial
    begin
        int cur_target;
        int new_gain;
        int hi;
        int n;
        int random_items;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: speed extremes, rounding of odd sums, moves to and from zero error
        push_pair(0, 0);
        push_pair(16383, 16383);
        push_pair(-16384, -16384);
        push_pair(-16384, 16383);
        push_pair(1, 0);
        push_pair(-1, 0);
        wait_drained();

        // top setpoint and gain, spare data bits set: drive clamps high, feed-forward saturates
        write_reg(REG_SETPOINT, 16'hFFFF);
        write_reg(REG_GAIN, 16'hFFFF);
        push_pair(0, 0);
        push_pair(16383, 16383);
        push_pair(-16384, -16384);
        push_pair(16383, 16383);
        wait_drained();

        // zero gain at full speed: only crossings move the drive
        write_reg(REG_SETPOINT, 16'd9600);
        write_reg(REG_GAIN, 16'd0);
        push_pair(9600, 9600);
        push_pair(9601, 9600);
        push_pair(9601, 9601);
        wait_drained();

        // gain change with the setpoint kept: crossings average with the take-back value
        write_reg(REG_GAIN, 16'hFFFF);
        push_pair(0, 0);
        push_pair(16383, 16383);
        push_pair(-9600, -9600);
        wait_drained();

        // zero setpoint: feed-forward goes negative and saturates at zero
        write_reg(REG_SETPOINT, {2'b00, TARGET_RESET});
        write_reg(REG_GAIN, GAIN_RESET);
        push_pair(0, 0);
        push_pair(5, 5);
        wait_drained();

        // mid-range setpoint: feed-forward inside the range
        write_reg(REG_SETPOINT, 16'd5000);
        push_pair(4990, 4990);
        push_pair(5010, 5010);
        push_pair(5000, 5000);
        wait_drained();

        cur_target   = 5000;
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       cur_target = 0;
                1:       cur_target = 9600;
                2:       cur_target = 16383;
                3, 4:    ;
                5:       cur_target = $urandom_range(0, 16383);
                default: cur_target = $urandom_range(0, 9600);
            endcase
            case ($urandom_range(0, 7))
                0:       new_gain = 0;
                1:       new_gain = 65535;
                2:       new_gain = 6554;
                3:       new_gain = $urandom_range(0, 65535);
                default: new_gain = $urandom_range(1, 16000);
            endcase
            hi = $urandom_range(0, 3);
            write_reg(REG_SETPOINT, {hi[1:0], cur_target[13:0]});
            write_reg(REG_GAIN, new_gain[15:0]);
            n = $urandom_range(60, 250);
            repeat (n)
                pending_samples.push_back(make_pair(cur_target));
            random_items += n;
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (expected_drive_q.size() != 0)
            report_mismatch("results still outstanding", expected_drive_q.size(), 0);
        if (mismatch_count == 0)
            $display("PASS take_back_half_speed_controller_core");
        else
            $display("FAIL take_back_half_speed_controller_core");
        $finish;
    end

endmodule

### sim.f
hw/rtl/tbh_pkg.sv
hw/rtl/tbh_step.sv
hw/rtl/take_back_half_speed_controller_core.sv
tb/sv/take_back_half_speed_controller_core_tb.sv
